// ----- rtl/tlep_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlep_pkg
// Shared types and constants of the two-level eta/pt binner.
// ----------------------------------------------------------------------------
package tlep_pkg;

    localparam int MAX_ETA_EDGES = 16;
    localparam int MAX_PT_EDGES  = 32;

    localparam int ETA_IDX_W = $clog2(MAX_ETA_EDGES);
    localparam int PT_IDX_W  = $clog2(MAX_PT_EDGES);
    localparam int EDGE_W    = 24;
    localparam int AETA_W    = 17;
    localparam int CNT_W     = 6;
    localparam int NUM_W     = 5;
    localparam int MEM_AW    = ETA_IDX_W + PT_IDX_W;
    localparam int MEM_DEPTH = MAX_ETA_EDGES * MAX_PT_EDGES;

    localparam logic [EDGE_W-1:0] ETA_TOP_RESET = 24'd10240;
    localparam logic [EDGE_W-1:0] PT_TOP_RESET  = 24'd160000;
    localparam logic [CNT_W-1:0]  CNT_ROW0_RESET = 6'd2;
    localparam logic [NUM_W-1:0]  NUM_ETA_RESET  = 5'd2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef enum logic [1:0] {
        OP_WR_ETA   = 2'd0,
        OP_WR_PT    = 2'd1,
        OP_SET_CNT  = 2'd2,
        OP_CLASSIFY = 2'd3
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [ETA_IDX_W-1:0] row;
        logic [PT_IDX_W-1:0]  idx;
        logic [EDGE_W-1:0]    val;
        logic [CNT_W-1:0]     cnt;
        logic [AETA_W-1:0]    aeta;
        logic [EDGE_W-1:0]    pt;
    } t_job;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ETA_LO,
        S_ETA_HI,
        S_ETA_WALK,
        S_PT_START,
        S_PT_TOP,
        S_PT_BOT,
        S_PT_WALK,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/tlep_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlep_front
// Input side: accepts items, decodes the operation and folds eta to its
// magnitude before the item enters the job queue.
// ----------------------------------------------------------------------------
module tlep_front (
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  logic [3:0]                    i_row_index,
    input  logic [4:0]                    i_edge_index,
    input  logic [23:0]                   i_edge_value,
    input  logic [5:0]                    i_edge_count,
    input  logic signed [15:0]            i_eta_value,
    input  logic [23:0]                   i_pt_value,
    input  logic                          i_q_full,
    input  logic                          i_clearing,
    output logic                          o_q_push,
    output tlep_pkg::t_job                o_q_data
);
    import tlep_pkg::*;

    logic [AETA_W-1:0] eta_mag;

    // Two's complement magnitude; the most negative code gives 32768.
    always_comb begin
        if (i_eta_value[15]) begin
            eta_mag = 17'h10000 - {1'b0, i_eta_value};
        end else begin
            eta_mag = {1'b0, i_eta_value};
        end
    end

    assign o_in_stall = i_q_full || i_clearing;
    assign o_q_push   = i_in_valid && !o_in_stall;

    always_comb begin
        o_q_data.op   = t_op'(i_operation);
        o_q_data.row  = i_row_index;
        o_q_data.idx  = i_edge_index;
        o_q_data.val  = i_edge_value;
        o_q_data.cnt  = i_edge_count;
        o_q_data.aeta = eta_mag;
        o_q_data.pt   = i_pt_value;
    end

endmodule

// ----- rtl/tlep_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlep_queue
// Short job queue between the input side and the lookup engine.
// ----------------------------------------------------------------------------
module tlep_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tlep_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tlep_pkg::t_job  o_head
);
    import tlep_pkg::*;

    t_job               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;
    logic [Q_PTR_W:0]   n_count;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/tlep_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlep_back
// Lookup engine: holds the edge tables, carries out writes and walks the
// eta edges and then the pt edges of the hit row, one compare per cycle.
// ----------------------------------------------------------------------------
module tlep_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [4:0]                i_num_eta_edges,
    input  logic                      i_q_valid,
    input  tlep_pkg::t_job            i_q_head,
    output logic                      o_q_pop,
    output logic                      o_clearing,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_in_range,
    output logic [3:0]                o_eta_bin,
    output logic [4:0]                o_pt_bin
);
    import tlep_pkg::*;

    t_state               r_state;
    t_state               n_state;
    t_job                 r_job;
    logic [PT_IDX_W-1:0]  r_idx;
    logic [PT_IDX_W-1:0]  n_idx;
    logic [ETA_IDX_W-1:0] r_eta_bin;
    logic [ETA_IDX_W-1:0] n_eta_bin;
    logic [PT_IDX_W-1:0]  r_pt_bin;
    logic [PT_IDX_W-1:0]  n_pt_bin;
    logic [CNT_W-1:0]     r_np;
    logic [CNT_W-1:0]     n_np;
    logic                 r_hit;
    logic                 n_hit;
    logic [MEM_AW-1:0]    r_clr_cnt;

    logic [EDGE_W-1:0]    r_eta_edges [MAX_ETA_EDGES];
    logic [CNT_W-1:0]     r_cnts [MAX_ETA_EDGES];
    logic [EDGE_W-1:0]    r_pt_mem [MEM_DEPTH];
    logic [EDGE_W-1:0]    r_rd_data;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic [ETA_IDX_W-1:0] r_out_eta;
    logic [PT_IDX_W-1:0]  r_out_pt;

    logic [NUM_W-1:0]     ne;
    logic [CNT_W-1:0]     np_sel;
    logic [CNT_W-1:0]     cnt_row;
    logic [ETA_IDX_W-1:0] eta_rd_idx;
    logic [EDGE_W-1:0]    eta_rd;
    logic [EDGE_W-1:0]    eta_x;
    logic                 eta_more;
    logic                 pt_more;
    logic                 out_free;
    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_waddr;
    logic [EDGE_W-1:0]    mem_wdata;
    logic [MEM_AW-1:0]    mem_raddr;
    logic                 clr_last;
    logic                 wr_eta;
    logic                 wr_cnt;

    // Effective counts, saturated to the table size.
    assign ne = (i_num_eta_edges > NUM_W'(MAX_ETA_EDGES)) ? NUM_W'(MAX_ETA_EDGES)
                                                         : i_num_eta_edges;
    assign cnt_row = r_cnts[r_eta_bin];
    assign np_sel  = (cnt_row > CNT_W'(MAX_PT_EDGES)) ? CNT_W'(MAX_PT_EDGES) : cnt_row;

    always_comb begin
        case (r_state)
            S_ETA_LO: eta_rd_idx = '0;
            S_ETA_HI: eta_rd_idx = ETA_IDX_W'(ne - 1'b1);
            default:  eta_rd_idx = r_idx[ETA_IDX_W-1:0];
        endcase
    end

    assign eta_rd   = r_eta_edges[eta_rd_idx];
    assign eta_x    = {{(EDGE_W-AETA_W){1'b0}}, r_job.aeta};
    assign eta_more = ((r_idx + 1'b1) < ne) && (eta_x >= eta_rd);
    assign pt_more  = (({1'b0, r_idx} + 1'b1) < r_np) && (r_job.pt >= r_rd_data);
    assign out_free = !r_out_valid || !i_out_stall;
    assign clr_last = (r_clr_cnt == MEM_AW'(MEM_DEPTH - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && i_q_head.op == OP_CLASSIFY) begin
                    n_state = (ne >= NUM_W'(2)) ? S_ETA_LO : S_EMIT;
                end
            end
            S_ETA_LO:   n_state = (eta_x < eta_rd) ? S_EMIT : S_ETA_HI;
            S_ETA_HI:   n_state = (eta_x > eta_rd) ? S_EMIT : S_ETA_WALK;
            S_ETA_WALK: n_state = eta_more ? S_ETA_WALK : S_PT_START;
            S_PT_START: n_state = (np_sel >= CNT_W'(2)) ? S_PT_TOP : S_EMIT;
            S_PT_TOP:   n_state = (r_job.pt > r_rd_data) ? S_EMIT : S_PT_BOT;
            S_PT_BOT:   n_state = (r_job.pt < r_rd_data) ? S_EMIT : S_PT_WALK;
            S_PT_WALK:  n_state = pt_more ? S_PT_WALK : S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath controls
    always_comb begin
        o_q_pop   = 1'b0;
        wr_eta    = 1'b0;
        wr_cnt    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = {i_q_head.row, i_q_head.idx};
        mem_wdata = i_q_head.val;
        mem_raddr = {r_eta_bin, r_idx + 1'b1};
        n_idx     = r_idx;
        n_eta_bin = r_eta_bin;
        n_pt_bin  = r_pt_bin;
        n_np      = r_np;
        n_hit     = r_hit;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                mem_wdata = (r_clr_cnt == MEM_AW'(1)) ? PT_TOP_RESET : '0;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    n_hit     = 1'b0;
                    n_eta_bin = '0;
                    n_pt_bin  = '0;
                    n_idx     = '0;
                    case (i_q_head.op)
                        OP_WR_ETA:  wr_eta = 1'b1;
                        OP_WR_PT:   mem_we = 1'b1;
                        OP_SET_CNT: wr_cnt = 1'b1;
                        default:    n_hit  = 1'b0;
                    endcase
                end
            end
            S_ETA_HI: begin
                n_eta_bin = '0;
                n_idx     = PT_IDX_W'(1);
            end
            S_ETA_WALK: begin
                if (eta_more) begin
                    n_eta_bin = r_idx[ETA_IDX_W-1:0];
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_PT_START: begin
                n_np      = np_sel;
                mem_raddr = {r_eta_bin, PT_IDX_W'(np_sel - 1'b1)};
            end
            S_PT_TOP: begin
                mem_raddr = {r_eta_bin, PT_IDX_W'(0)};
            end
            S_PT_BOT: begin
                mem_raddr = {r_eta_bin, PT_IDX_W'(1)};
                n_pt_bin  = '0;
                n_idx     = PT_IDX_W'(1);
            end
            S_PT_WALK: begin
                if (pt_more) begin
                    n_pt_bin = r_idx;
                    n_idx    = r_idx + 1'b1;
                end else begin
                    n_hit = 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_in_range  = r_out_hit;
    assign o_eta_bin   = r_out_eta;
    assign o_pt_bin    = r_out_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_hit       <= 1'b0;
            for (int k = 0; k < MAX_ETA_EDGES; k++) begin
                r_eta_edges[k] <= (k == 1) ? ETA_TOP_RESET : '0;
                r_cnts[k]      <= (k == 0) ? CNT_ROW0_RESET : '0;
            end
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (wr_eta) begin
                r_eta_edges[i_q_head.row] <= i_q_head.val;
            end
            if (wr_cnt) begin
                r_cnts[i_q_head.row] <= i_q_head.cnt;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_eta_bin <= n_eta_bin;
        r_pt_bin  <= n_pt_bin;
        r_np      <= n_np;
        if (o_q_pop) begin
            r_job <= i_q_head;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_hit <= r_hit;
            r_out_eta <= r_hit ? r_eta_bin : '0;
            r_out_pt  <= r_hit ? r_pt_bin : '0;
        end
    end

    // Edge memory with one write port, one read port and registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pt_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_pt_mem[mem_raddr];
    end

endmodule

// ----- rtl/two_level_eta_pt_binner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_eta_pt_binner_unit
// Two-level binner: eta bin of |eta|, then pt bin within that eta row.
//
// Input channel (i_in_valid / o_in_stall) takes write items (eta edge,
// pt edge, row pt count) and classify items. Each classify item yields one
// transfer on the output channel (o_out_valid / i_out_stall); writes yield
// none. The eta edge count in use is set through the APB register at offset 0.
// The lookup engine makes one edge compare per cycle on a classify item,
// walking up to 16 eta edges in registers and then up to 32 pt edges in the
// edge memory (one write port, one read port), whose registered read sets
// that pace. Items queue two deep ahead of the engine. After reset the pt
// edge memory is loaded with its default contents; o_in_stall is high during
// that pass. When the receiver stalls, the finished result holds in the
// output register, the engine waits with the next result, and the input side
// keeps taking items until the queue is full.
// ----------------------------------------------------------------------------
module two_level_eta_pt_binner_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [3:0]         i_row_index,
    input  logic [4:0]         i_edge_index,
    input  logic [23:0]        i_edge_value,
    input  logic [5:0]         i_edge_count,
    input  logic signed [15:0] i_eta_value,
    input  logic [23:0]        i_pt_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_in_range,
    output logic [3:0]         o_eta_bin,
    output logic [4:0]         o_pt_bin,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tlep_pkg::*;

    logic [NUM_W-1:0] r_num_eta_edges;
    logic             cfg_wr;
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic             clearing;
    t_job             q_in;
    t_job             q_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32-NUM_W){1'b0}}, r_num_eta_edges};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_eta_edges <= NUM_ETA_RESET;
        end else if (cfg_wr) begin
            r_num_eta_edges <= pwdata[NUM_W-1:0];
        end
    end

    tlep_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_row_index  (i_row_index),
        .i_edge_index (i_edge_index),
        .i_edge_value (i_edge_value),
        .i_edge_count (i_edge_count),
        .i_eta_value  (i_eta_value),
        .i_pt_value   (i_pt_value),
        .i_q_full     (q_full),
        .i_clearing   (clearing),
        .o_q_push     (q_push),
        .o_q_data     (q_in)
    );

    tlep_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    tlep_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_num_eta_edges (r_num_eta_edges),
        .i_q_valid       (q_valid),
        .i_q_head        (q_head),
        .o_q_pop         (q_pop),
        .o_clearing      (clearing),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_in_range      (o_in_range),
        .o_eta_bin       (o_eta_bin),
        .o_pt_bin        (o_pt_bin)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-level eta/pt binner. A short directed table
// covers reset contents, field extremes and the degenerate edge-count cases.
// Random phases then follow: each phase sets the eta edge count over APB,
// loads ascending eta and pt edges, and classifies values aimed at the bins,
// with some noise items mixed in. A local model of the edge tables predicts
// each classify result that the directed table does not give. The sender
// idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
    import tlep_pkg::*;

    localparam logic [2:0] REG_NUM_ETA_EDGES = 3'd0;
    localparam int         DRAIN_CYCLES      = 80;
    localparam int         N_DIR             = 23;

    typedef struct packed {
        t_op                  op;
        logic [3:0]           row;
        logic [4:0]           idx;
        logic [EDGE_W-1:0]    val;
        logic [CNT_W-1:0]     cnt;
        logic signed [15:0]   eta;
        logic [EDGE_W-1:0]    pt;
    } t_bin_item;

    typedef struct packed {
        logic       hit;
        logic [3:0] eta_bin;
        logic [4:0] pt_bin;
    } t_bin_result;

    typedef struct packed {
        t_bin_item   item;
        logic        typed;
        t_bin_result res;
    } t_stim_row;

    typedef enum {RX_FREE, RX_RANDOM, RX_BURSTS} t_rx_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_operation;
    logic [3:0]         i_row_index;
    logic [4:0]         i_edge_index;
    logic [23:0]        i_edge_value;
    logic [5:0]         i_edge_count;
    logic signed [15:0] i_eta_value;
    logic [23:0]        i_pt_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_in_range;
    logic [3:0]         o_eta_bin;
    logic [4:0]         o_pt_bin;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    two_level_eta_pt_binner_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_row_index  (i_row_index),
        .i_edge_index (i_edge_index),
        .i_edge_value (i_edge_value),
        .i_edge_count (i_edge_count),
        .i_eta_value  (i_eta_value),
        .i_pt_value   (i_pt_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_in_range   (o_in_range),
        .o_eta_bin    (o_eta_bin),
        .o_pt_bin     (o_pt_bin),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Local copy of the binner state.
    logic [EDGE_W-1:0] eta_bounds [MAX_ETA_EDGES];
    logic [EDGE_W-1:0] pt_bounds  [MAX_ETA_EDGES][MAX_PT_EDGES];
    logic [CNT_W-1:0]  pt_counts  [MAX_ETA_EDGES];
    logic [NUM_W-1:0]  eta_edges_used;

    t_bin_result pending_bins [$];
    t_bin_result want;
    int          mismatch_count = 0;
    int          burst_left     = 0;
    t_stim_row   dir_rows [N_DIR];
    int          phase_cfg [8];

    t_rx_mode rx_mode      = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_run       = 0;
    logic     rx_hold      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("two_level_eta_pt_binner_unit verification failed");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic bins_reset();
        int r;
        int c;
        for (r = 0; r < MAX_ETA_EDGES; r++) begin
            eta_bounds[r] = '0;
            pt_counts[r]  = '0;
            for (c = 0; c < MAX_PT_EDGES; c++) pt_bounds[r][c] = '0;
        end
        eta_bounds[1]   = ETA_TOP_RESET;
        pt_bounds[0][1] = PT_TOP_RESET;
        pt_counts[0]    = CNT_ROW0_RESET;
        eta_edges_used  = NUM_ETA_RESET;
    endtask

    // Both ends of the range are inclusive; the bin is the last edge at or
    // below x, walking upward and stopping one short of the top edge.
    function automatic logic edge_search(input logic [EDGE_W-1:0] x,
                                         input logic [EDGE_W-1:0] e [MAX_PT_EDGES],
                                         input int n, output logic [4:0] bin);
        int i;
        bin = '0;
        if (x < e[0] || x > e[n-1]) return 1'b0;
        for (i = 0; i + 1 < n; i++) begin
            if (x >= e[i]) bin = 5'(i);
            else break;
        end
        return 1'b1;
    endfunction

    task automatic binner_accept(input t_bin_item it, input logic typed,
                                 input t_bin_result typed_res);
        logic [15:0]       raw;
        logic [16:0]       mag;
        logic [EDGE_W-1:0] row_e [MAX_PT_EDGES];
        logic [4:0]        eb;
        logic [4:0]        pb;
        logic              hit;
        int                ne;
        int                np;
        int                i;
        t_bin_result       r;
        case (it.op)
            OP_WR_ETA:  eta_bounds[it.row] = it.val;
            OP_WR_PT:   pt_bounds[it.row][it.idx] = it.val;
            OP_SET_CNT: pt_counts[it.row] = it.cnt;
            OP_CLASSIFY: begin
                raw = it.eta;
                // The most negative eta folds to 32768, hence 17 bits.
                mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
                ne  = (eta_edges_used > MAX_ETA_EDGES) ? MAX_ETA_EDGES
                                                       : int'(eta_edges_used);
                hit = 1'b0;
                eb  = '0;
                pb  = '0;
                if (ne >= 2) begin
                    for (i = 0; i < MAX_PT_EDGES; i++)
                        row_e[i] = (i < MAX_ETA_EDGES) ? eta_bounds[i] : '0;
                    if (edge_search({7'd0, mag}, row_e, ne, eb)) begin
                        np = (pt_counts[eb[3:0]] > MAX_PT_EDGES) ? MAX_PT_EDGES
                                                                 : int'(pt_counts[eb[3:0]]);
                        for (i = 0; i < MAX_PT_EDGES; i++) row_e[i] = pt_bounds[eb[3:0]][i];
                        if (np >= 2 && edge_search(it.pt, row_e, np, pb)) hit = 1'b1;
                    end
                end
                r.hit     = hit;
                r.eta_bin = hit ? eb[3:0] : 4'd0;
                r.pt_bin  = hit ? pb : 5'd0;
                pending_bins.insert(pending_bins.size(), typed ? typed_res : r);
            end
            default: ;
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input t_bin_item it, input logic typed,
                             input t_bin_result typed_res);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= it.op;
        i_row_index  <= it.row;
        i_edge_index <= it.idx;
        i_edge_value <= it.val;
        i_edge_count <= it.cnt;
        i_eta_value  <= it.eta;
        i_pt_value   <= it.pt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        binner_accept(it, typed, typed_res);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wr ? data : 32'd0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (wr) begin
            if (addr == REG_NUM_ETA_EDGES) eta_edges_used = data[NUM_W-1:0];
        end else if (prdata !== data) begin
            flag_mismatch($sformatf("register %0d read %0d, expected %0d", addr, prdata, data));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_bins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic t_bin_item rand_item();
        t_bin_item it;
        it.op  = t_op'($urandom_range(0, 3));
        it.row = 4'($urandom_range(0, 15));
        it.idx = 5'($urandom_range(0, 31));
        it.val = 24'($urandom());
        it.cnt = 6'($urandom_range(0, 63));
        it.eta = 16'($urandom());
        it.pt  = 24'($urandom());
        return it;
    endfunction

    task automatic maybe_noise();
        if ($urandom_range(0, 14) == 0) send_item(rand_item(), 1'b0, '0);
    endtask

    task automatic run_phase(input int cfg, input int n_cls);
        t_bin_item it;
        int        ne;
        int        b;
        int        k;
        int        n;
        int        cnt;
        int        step;
        int        lo;
        int        hi;
        int        m;
        int        p;
        int        sel;
        logic      neg;
        wait_drained();
        reg_access(1'b1, REG_NUM_ETA_EDGES, 32'(cfg));
        reg_access(1'b0, REG_NUM_ETA_EDGES, 32'(cfg));
        ne = (cfg > MAX_ETA_EDGES) ? MAX_ETA_EDGES : cfg;

        if (ne >= 2) begin
            step = $urandom_range(2, 32000 / (ne - 1));
            for (k = 0; k < ne; k++) begin
                it     = rand_item();
                it.op  = OP_WR_ETA;
                it.row = 4'(k);
                it.val = 24'(k * step + $urandom_range(0, step / 2 - 1));
                if (k == ne - 1 && $urandom_range(0, 3) == 0) it.val = 24'd32768;
                maybe_noise();
                send_item(it, 1'b0, '0);
            end
            for (b = 0; b < ne - 1; b++) begin
                sel = $urandom_range(0, 99);
                if (sel < 85)      cnt = $urandom_range(2, 5);
                else if (sel < 90) cnt = MAX_PT_EDGES;
                else if (sel < 94) cnt = $urandom_range(MAX_PT_EDGES + 1, 63);
                else               cnt = $urandom_range(0, 1);
                it     = rand_item();
                it.op  = OP_SET_CNT;
                it.row = 4'(b);
                it.cnt = 6'(cnt);
                send_item(it, 1'b0, '0);
                n = (cnt > MAX_PT_EDGES) ? MAX_PT_EDGES : cnt;
                if (n >= 2) begin
                    step = $urandom_range(1, 16_000_000 / (n - 1));
                    p    = $urandom_range(0, 4000);
                    for (k = 0; k < n; k++) begin
                        if (k > 0) p = p + $urandom_range(1, step);
                        it     = rand_item();
                        it.op  = OP_WR_PT;
                        it.row = 4'(b);
                        it.idx = 5'(k);
                        it.val = 24'(p);
                        maybe_noise();
                        send_item(it, 1'b0, '0);
                    end
                end
            end
        end

        for (k = 0; k < n_cls; k++) begin
            it    = rand_item();
            it.op = OP_CLASSIFY;
            sel   = $urandom_range(0, 19);
            if (sel < 17 && ne >= 2) begin
                // Aim at a bin: its edges, its interior, then the pt row behind it.
                b  = $urandom_range(0, ne - 2);
                lo = eta_bounds[b];
                hi = eta_bounds[b + 1];
                case ($urandom_range(0, 4))
                    0:       m = lo;
                    1:       m = hi;
                    default: m = (lo <= hi) ? int'($urandom_range(hi, lo)) : lo;
                endcase
                if (m > 32768) m = $urandom_range(0, 32768);
                neg    = ($urandom_range(0, 1) == 1) || (m == 32768);
                it.eta = neg ? 16'(-m) : 16'(m);
                n = (pt_counts[b] > MAX_PT_EDGES) ? MAX_PT_EDGES : int'(pt_counts[b]);
                if (n >= 2 && $urandom_range(0, 9) != 0) begin
                    lo = pt_bounds[b][0];
                    hi = pt_bounds[b][n-1];
                    if ($urandom_range(0, 3) == 0)
                        it.pt = pt_bounds[b][$urandom_range(0, n - 1)];
                    else if (lo <= hi)
                        it.pt = 24'($urandom_range(hi, lo));
                end
            end else if (sel == 19) begin
                it = rand_item();
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bins.size() == 0) begin
                flag_mismatch($sformatf("unexpected result in_range=%0b eta_bin=%0d pt_bin=%0d",
                                        o_in_range, o_eta_bin, o_pt_bin));
            end else begin
                want = pending_bins.pop_front();
                if (o_in_range !== want.hit)
                    flag_mismatch($sformatf("in_range got %0b, expected %0b",
                                            o_in_range, want.hit));
                if (o_eta_bin !== want.eta_bin)
                    flag_mismatch($sformatf("eta_bin got %0d, expected %0d",
                                            o_eta_bin, want.eta_bin));
                if (o_pt_bin !== want.pt_bin)
                    flag_mismatch($sformatf("pt_bin got %0d, expected %0d",
                                            o_pt_bin, want.pt_bin));
            end
        end
    end

    // Receiver back-pressure: free-running, random, or long stall bursts.
    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(50, 300);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_FREE:   i_out_stall <= 1'b0;
            RX_RANDOM: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (rx_run == 0) begin
                    rx_hold = !rx_hold;
                    rx_run  = rx_hold ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                rx_run--;
                i_out_stall <= rx_hold;
            end
        endcase
    end

    initial begin
        int r;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = '0;
        i_row_index  = '0;
        i_edge_index = '0;
        i_edge_value = '0;
        i_edge_count = '0;
        i_eta_value  = '0;
        i_pt_value   = '0;
        i_out_stall  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        bins_reset();

        dir_rows = '{
            // Reset tables: eta 0..10240 in one bin, pt 0..160000 in one bin.
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd0, 24'd0}, 1'b1, '{1'b1, 4'd0, 5'd0}},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd10240, 24'd160000}, 1'b1,
              '{1'b1, 4'd0, 5'd0}},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, -16'sd10240, 24'd80000}, 1'b1,
              '{1'b1, 4'd0, 5'd0}},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd10241, 24'd0}, 1'b1, '{1'b0, 4'd0, 5'd0}},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sh8000, 24'd0}, 1'b1, '{1'b0, 4'd0, 5'd0}},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd32767, 24'd0}, 1'b1, '{1'b0, 4'd0, 5'd0}},
            // Eta hits but pt misses.
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd0, 24'd160001}, 1'b1,
              '{1'b0, 4'd0, 5'd0}},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, -16'sd1, 24'hFFFFFF}, 1'b1,
              '{1'b0, 4'd0, 5'd0}},
            '{'{OP_WR_ETA, 4'd15, 5'd0, 24'hFFFFFF, 6'd0, 16'sd0, 24'd0}, 1'b0, '0},
            '{'{OP_WR_ETA, 4'd1, 5'd0, 24'd32768, 6'd0, 16'sd0, 24'd0}, 1'b0, '0},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sh8000, 24'd5}, 1'b0, '0},
            '{'{OP_WR_PT, 4'd15, 5'd31, 24'hFFFFFF, 6'd0, 16'sd0, 24'd0}, 1'b0, '0},
            '{'{OP_SET_CNT, 4'd15, 5'd0, 24'd0, 6'd32, 16'sd0, 24'd0}, 1'b0, '0},
            // Count above the row size saturates; the upper edges are zero.
            '{'{OP_SET_CNT, 4'd0, 5'd0, 24'd0, 6'd63, 16'sd0, 24'd0}, 1'b0, '0},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd5, 24'd0}, 1'b0, '0},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd5, 24'd1}, 1'b0, '0},
            '{'{OP_WR_PT, 4'd0, 5'd31, 24'hFFFFFF, 6'd0, 16'sd0, 24'd0}, 1'b0, '0},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd100, 24'hFFFFFF}, 1'b0, '0},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd100, 24'd160000}, 1'b0, '0},
            // Fewer than two pt edges always misses.
            '{'{OP_SET_CNT, 4'd0, 5'd0, 24'd0, 6'd1, 16'sd0, 24'd0}, 1'b0, '0},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd0, 24'd0}, 1'b1, '{1'b0, 4'd0, 5'd0}},
            '{'{OP_SET_CNT, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd0, 24'd0}, 1'b0, '0},
            '{'{OP_CLASSIFY, 4'd0, 5'd0, 24'd0, 6'd0, 16'sd7, 24'd0}, 1'b1, '{1'b0, 4'd0, 5'd0}}
        };

        phase_cfg = '{16, 2, 0, 1, 17, 31, 0, 0};
        phase_cfg[6] = $urandom_range(3, 15);
        phase_cfg[7] = $urandom_range(0, 31);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // The pt memory is reloaded after reset; input stays stalled until done.
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        reg_access(1'b0, REG_NUM_ETA_EDGES, 32'(NUM_ETA_RESET));

        for (r = 0; r < N_DIR; r++)
            send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].res);

        for (r = 0; r < 8; r++)
            run_phase(phase_cfg[r], 40);

        wait_drained();
        if (mismatch_count == 0)
            $display("two_level_eta_pt_binner_unit verification clean");
        else
            $display("two_level_eta_pt_binner_unit verification failed");
        $finish;
    end

endmodule

// ----- two_level_eta_pt_binner_unit.f -----
rtl/tlep_pkg.sv
rtl/tlep_front.sv
rtl/tlep_queue.sv
rtl/tlep_back.sv
rtl/two_level_eta_pt_binner_unit.sv
tb/testbench.sv
